// ===== design/midi_channel_message_parser_unit_macros.svh =====
// Assertion macros for the MIDI channel message parser checks.
`ifndef MIDI_CHANNEL_MESSAGE_PARSER_UNIT_MACROS_SVH
`define MIDI_CHANNEL_MESSAGE_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, off while in reset.
`define MCMP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("mcmp check failed");

// Next-cycle implication, off while in reset.
`define MCMP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("mcmp check failed");

`endif

// ===== design/mcmp_pkg.sv =====
// Types and constants shared by the MIDI channel message parser files.
package mcmp_pkg;

	localparam logic [7:0] RT_FIRST   = 8'hF8;
	localparam logic [7:0] SYS_FIRST  = 8'hF0;
	localparam logic [7:0] SYS_EOX    = 8'hF7;
	localparam logic [7:0] STATUS_BIT = 8'h80;
	localparam logic [7:0] KIND_MASK  = 8'hF0;
	localparam logic [7:0] KIND_PROG  = 8'hC0;
	localparam logic [7:0] KIND_PRESS = 8'hD0;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       chunk_last;
	} midi_in_t;

	typedef struct packed {
		logic [7:0] status_byte;
		logic [6:0] first_data;
		logic [6:0] second_data;
	} midi_msg_t;

endpackage

// ===== design/midi_channel_message_parser_unit.sv =====
// MIDI channel message parser: raw bytes in, complete channel messages out.
//
//   channel  dir  handshake              payload
//   midi     in   midi_valid/midi_ready  mcmp_pkg::midi_in_t
//   msg      out  msg_valid/msg_ready    mcmp_pkg::midi_msg_t
//
// One byte per cycle unless the output stalls; a byte is decoded in the cycle
// after its transfer, and a completed message is then loaded into the output.
// arst_n clears running status, the held/length flags and both valid flags.
// A full output register that is not taken stalls the input register only
// when the byte waiting there completes a message; other bytes keep flowing.
module midi_channel_message_parser_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                midi_valid,
	output logic                midi_ready,
	input  mcmp_pkg::midi_in_t  midi,
	output logic                msg_valid,
	input  logic                msg_ready,
	output mcmp_pkg::midi_msg_t msg
);
	import mcmp_pkg::*;

	logic       valid_s1;
	logic [7:0] data_s1;

	logic [7:0] status_q;
	logic       two_q;
	logic       held_q;
	logic [6:0] first_q;
	logic       sys_q;

	logic      msg_valid_q;
	midi_msg_t msg_q;

	logic       is_rt;
	logic       is_sys;
	logic       is_chan;
	logic       is_data;
	logic       has_status;
	logic       take_first;
	logic       emit;
	logic       adv;
	logic [7:0] kind;
	logic       one_byte;
	midi_msg_t  msg_d;

	always_comb begin
		is_rt      = (data_s1 >= RT_FIRST);
		is_sys     = !is_rt && (data_s1 >= SYS_FIRST);
		is_chan    = ((data_s1 & STATUS_BIT) != '0) && (data_s1 < SYS_FIRST);
		is_data    = ((data_s1 & STATUS_BIT) == '0);
		has_status = (status_q != '0);
		take_first = is_data && !sys_q && has_status && !held_q && two_q;
		emit       = is_data && !sys_q && has_status && !take_first;
		adv        = valid_s1 && (!emit || !msg_valid_q || msg_ready);
		midi_ready = !valid_s1 || adv;
		kind       = data_s1 & KIND_MASK;
		one_byte   = (kind == KIND_PROG) || (kind == KIND_PRESS);

		msg_d.status_byte = status_q;
		if (two_q) begin
			msg_d.first_data  = first_q;
			msg_d.second_data = data_s1[6:0];
		end else begin
			msg_d.first_data  = data_s1[6:0];
			msg_d.second_data = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (midi_ready) begin
			valid_s1 <= midi_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (midi_valid && midi_ready) begin
			data_s1 <= midi.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= '0;
			two_q    <= 1'b0;
			held_q   <= 1'b0;
			sys_q    <= 1'b0;
		end else if (adv) begin
			priority if (is_rt) begin
				status_q <= status_q;
			end else if (is_sys) begin
				sys_q    <= (data_s1 != SYS_EOX);
				status_q <= '0;
				held_q   <= 1'b0;
			end else if (is_chan) begin
				sys_q    <= 1'b0;
				status_q <= data_s1;
				two_q    <= !one_byte;
				held_q   <= 1'b0;
			end else if (take_first) begin
				held_q <= 1'b1;
			end else if (emit) begin
				held_q <= 1'b0;
			end else begin
				held_q <= held_q;
			end
		end
	end

	// hold the first data byte of a two-byte message
	always_ff @(posedge clk) begin
		if (adv && take_first) begin
			first_q <= data_s1[6:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_valid_q <= 1'b0;
		end else if (adv && emit) begin
			msg_valid_q <= 1'b1;
		end else if (msg_ready) begin
			msg_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			msg_q <= msg_d;
		end
	end

	assign msg_valid = msg_valid_q;
	assign msg       = msg_q;

endmodule

// ===== design/mcmp_checker.sv =====
// Port-level checks for the MIDI channel message parser, bound to the top level.
`include "midi_channel_message_parser_unit_macros.svh"

module mcmp_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                midi_valid,
	input logic                midi_ready,
	input logic                msg_valid,
	input logic                msg_ready,
	input mcmp_pkg::midi_msg_t msg
);
	import mcmp_pkg::*;

	logic midi_xfer;
	logic one_byte_kind;
	logic status_ok;

	assign midi_xfer     = midi_valid && midi_ready;
	assign one_byte_kind = ((msg.status_byte & KIND_MASK) == KIND_PROG) ||
		((msg.status_byte & KIND_MASK) == KIND_PRESS);
	assign status_ok     = ((msg.status_byte & STATUS_BIT) != '0) &&
		(msg.status_byte < SYS_FIRST);

	`MCMP_ASSERT_NXT(a_msg_hold, clk, arst_n, msg_valid && !msg_ready, msg_valid && $stable(msg))
	`MCMP_ASSERT_IMP(a_status_range, clk, arst_n, msg_valid, status_ok)
	`MCMP_ASSERT_IMP(a_one_byte_zero, clk, arst_n, msg_valid && one_byte_kind, msg.second_data == '0)
	`MCMP_ASSERT_IMP(a_msg_needs_byte, clk, arst_n, $rose(msg_valid), $past(midi_xfer, 2))

endmodule

bind midi_channel_message_parser_unit mcmp_checker u_mcmp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.midi_valid (midi_valid),
	.midi_ready (midi_ready),
	.msg_valid  (msg_valid),
	.msg_ready  (msg_ready),
	.msg        (msg)
);

// ===== dv/tb_top.sv =====
// Testbench for the MIDI channel message parser: directed and random byte streams, checked per field.
`timescale 1ns / 1ps

module tb_top;
	import mcmp_pkg::*;

	localparam int RAND_ITEMS = 400;
	localparam int DRAIN_EVERY = 120;
	localparam int SETTLE_CYCLES = 20;
	localparam int DIR_LEN = 29;

	typedef struct packed {
		logic [7:0] b;
		logic       last;
		logic       typed;
		logic       has;
		logic [7:0] st;
		logic [6:0] d1;
		logic [6:0] d2;
	} step_row_t;

	localparam step_row_t DIR_STEPS [DIR_LEN] = '{
		'{8'h00,      1'b0, 1'b1, 1'b0, 8'h00, 7'h00, 7'h00},
		'{8'h7F,      1'b1, 1'b1, 1'b0, 8'h00, 7'h00, 7'h00},
		'{8'h90,      1'b0, 1'b1, 1'b0, 8'h00, 7'h00, 7'h00},
		'{8'h3C,      1'b0, 1'b1, 1'b0, 8'h00, 7'h00, 7'h00},
		'{8'h7F,      1'b1, 1'b1, 1'b1, 8'h90, 7'h3C, 7'h7F},
		'{8'h00,      1'b0, 1'b1, 1'b0, 8'h00, 7'h00, 7'h00},
		'{8'h00,      1'b0, 1'b1, 1'b1, 8'h90, 7'h00, 7'h00},
		'{8'h40,      1'b0, 1'b1, 1'b0, 8'h00, 7'h00, 7'h00},
		'{RT_FIRST,   1'b1, 1'b1, 1'b0, 8'h00, 7'h00, 7'h00},
		'{8'h41,      1'b0, 1'b1, 1'b1, 8'h90, 7'h40, 7'h41},
		'{8'hCF,      1'b0, 1'b1, 1'b0, 8'h00, 7'h00, 7'h00},
		'{8'h7F,      1'b0, 1'b1, 1'b1, 8'hCF, 7'h7F, 7'h00},
		'{8'h00,      1'b1, 1'b1, 1'b1, 8'hCF, 7'h00, 7'h00},
		'{8'hD5,      1'b0, 1'b1, 1'b0, 8'h00, 7'h00, 7'h00},
		'{8'h12,      1'b0, 1'b1, 1'b1, 8'hD5, 7'h12, 7'h00},
		'{8'hEF,      1'b0, 1'b1, 1'b0, 8'h00, 7'h00, 7'h00},
		'{8'h00,      1'b0, 1'b1, 1'b0, 8'h00, 7'h00, 7'h00},
		'{8'hFF,      1'b1, 1'b1, 1'b0, 8'h00, 7'h00, 7'h00},
		'{8'h7F,      1'b0, 1'b1, 1'b1, 8'hEF, 7'h00, 7'h7F},
		'{SYS_FIRST,  1'b0, 1'b0, 1'b0, 8'h00, 7'h00, 7'h00},
		'{8'h12,      1'b0, 1'b0, 1'b0, 8'h00, 7'h00, 7'h00},
		'{SYS_EOX,    1'b0, 1'b0, 1'b0, 8'h00, 7'h00, 7'h00},
		'{8'h34,      1'b1, 1'b0, 1'b0, 8'h00, 7'h00, 7'h00},
		'{8'hA3,      1'b0, 1'b0, 1'b0, 8'h00, 7'h00, 7'h00},
		'{8'h05,      1'b0, 1'b0, 1'b0, 8'h00, 7'h00, 7'h00},
		'{SYS_EOX - 8'h01, 1'b0, 1'b0, 1'b0, 8'h00, 7'h00, 7'h00},
		'{8'h80,      1'b0, 1'b0, 1'b0, 8'h00, 7'h00, 7'h00},
		'{8'h01,      1'b0, 1'b0, 1'b0, 8'h00, 7'h00, 7'h00},
		'{8'h02,      1'b1, 1'b0, 1'b0, 8'h00, 7'h00, 7'h00}
	};

	logic      clk = 1'b0;
	logic      arst_n;
	logic      midi_valid;
	logic      midi_ready;
	midi_in_t  midi;
	logic      msg_valid;
	logic      msg_ready;
	midi_msg_t msg;

	midi_msg_t pending_msgs[$];
	int        mismatches = 0;
	int        item_count = 0;
	int        ready_hold = 0;
	bit        calm = 1'b0;

	logic [7:0] run_status = '0;
	logic [1:0] need_cnt = '0;
	logic [1:0] held_cnt = '0;
	logic [6:0] held_d1 = '0;
	bit         in_sysex = 1'b0;

	midi_channel_message_parser_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.midi_valid (midi_valid),
		.midi_ready (midi_ready),
		.midi       (midi),
		.msg_valid  (msg_valid),
		.msg_ready  (msg_ready),
		.msg        (msg)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit parse_byte(input logic [7:0] b, output midi_msg_t m);
		logic [7:0] kind;
		m = '0;
		kind = b & KIND_MASK;
		if (b >= RT_FIRST)
			return 1'b0;
		if (b >= SYS_FIRST) begin
			in_sysex = (b != SYS_EOX);
			run_status = '0;
			held_cnt = '0;
			return 1'b0;
		end
		if ((b & STATUS_BIT) != 8'h00) begin
			in_sysex = 1'b0;
			run_status = b;
			need_cnt = (kind == KIND_PROG || kind == KIND_PRESS) ? 2'd1 : 2'd2;
			held_cnt = '0;
			return 1'b0;
		end
		if (in_sysex || run_status == 8'h00)
			return 1'b0;
		if (held_cnt == 2'd0 && need_cnt >= 2'd2) begin
			held_d1 = b[6:0];
			held_cnt = 2'd1;
			return 1'b0;
		end
		m.status_byte = run_status;
		if (need_cnt >= 2'd2) begin
			m.first_data = held_d1;
			m.second_data = b[6:0];
		end else begin
			m.first_data = b[6:0];
			m.second_data = '0;
		end
		held_cnt = '0;
		return 1'b1;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_msg(input midi_msg_t got);
		midi_msg_t want;
		if (pending_msgs.size() == 0) begin
			report_mismatch($sformatf("unexpected message %h %h %h",
				got.status_byte, got.first_data, got.second_data));
		end else begin
			want = pending_msgs.pop_front();
			if (got.status_byte !== want.status_byte)
				report_mismatch($sformatf("status_byte %h, want %h",
					got.status_byte, want.status_byte));
			if (got.first_data !== want.first_data)
				report_mismatch($sformatf("first_data %h, want %h",
					got.first_data, want.first_data));
			if (got.second_data !== want.second_data)
				report_mismatch($sformatf("second_data %h, want %h",
					got.second_data, want.second_data));
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
			input bit has, input midi_msg_t typed_msg);
		int        gap;
		midi_msg_t pm;
		bit        got;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			midi_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		midi_valid <= 1'b1;
		midi <= '{data_byte: b, chunk_last: last};
		do @(posedge clk); while (!midi_ready);
		got = parse_byte(b, pm);
		if (typed) begin
			if (has)
				pending_msgs.push_back(typed_msg);
		end else if (got) begin
			pending_msgs.push_back(pm);
		end
		if (b < RT_FIRST)
			item_count++;
	endtask

	task automatic push_byte(input logic [7:0] b);
		send_byte(b, 1'($urandom_range(0, 1)), 1'b0, 1'b0, '0);
	endtask

	task automatic wait_drained();
		midi_valid <= 1'b0;
		@(posedge clk);
		while (pending_msgs.size() != 0) @(posedge clk);
	endtask

	task automatic push_status();
		logic [3:0] kind;
		kind = 4'($urandom_range(8, 14));
		push_byte({kind, 4'($urandom_range(0, 15))});
	endtask

	task automatic run_random();
		int target;
		int next_drain;
		int r;
		int n;
		target = item_count + RAND_ITEMS;
		next_drain = item_count + DRAIN_EVERY;
		while (item_count < target) begin
			if ($urandom_range(0, 39) == 0)
				calm = !calm;
			if (item_count >= next_drain) begin
				wait_drained();
				next_drain += DRAIN_EVERY;
			end
			r = $urandom_range(0, 99);
			if (r < 75) begin
				if (run_status == 8'h00 || $urandom_range(0, 2) == 0)
					push_status();
				n = need_cnt;
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(0, 7) == 0)
						push_byte(RT_FIRST + 8'($urandom_range(0, 7)));
					push_byte(8'($urandom_range(0, 127)));
				end
			end else if (r < 85) begin
				push_byte(SYS_FIRST + 8'($urandom_range(0, 7)));
				n = $urandom_range(0, 4);
				for (int i = 0; i < n; i++)
					push_byte(8'($urandom_range(0, 127)));
				if ($urandom_range(0, 1) == 0)
					push_byte(SYS_EOX);
			end else if (r < 93) begin
				push_status();
				push_byte(8'($urandom_range(0, 127)));
			end else begin
				push_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && msg_valid && msg_ready)
			check_msg(msg);
		if (ready_hold > 0) begin
			msg_ready <= 1'b0;
			ready_hold--;
		end else begin
			msg_ready <= 1'b1;
			if (!calm && $urandom_range(0, 3) == 0)
				ready_hold = pick_gap();
		end
	end

	initial begin
		arst_n <= 1'b0;
		midi_valid <= 1'b0;
		midi <= '0;
		msg_ready <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < DIR_LEN; i++)
			send_byte(DIR_STEPS[i].b, DIR_STEPS[i].last, DIR_STEPS[i].typed,
				DIR_STEPS[i].has,
				'{DIR_STEPS[i].st, DIR_STEPS[i].d1, DIR_STEPS[i].d2});
		wait_drained();
		run_random();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_msgs.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/mcmp_pkg.sv
design/midi_channel_message_parser_unit.sv
design/mcmp_checker.sv
dv/tb_top.sv
